[rtl/pcmmix_pkg.sv]
// Shared widths, codes and constants of the PCM mixer.
package pcmmix_pkg;

	localparam int NUM_SOURCES = 4;
	localparam int SAMPLE_W    = 16;
	localparam int VOL_W       = 8;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = $clog2(NUM_SOURCES + 2);

	localparam int SUM_W       = SAMPLE_W + $clog2(NUM_SOURCES);
	localparam int CH_MAG_W    = SAMPLE_W + VOL_W - 1;
	localparam int CH_Q_W      = SAMPLE_W;
	localparam int MS_MAG_W    = SUM_W + VOL_W - 1;
	localparam int MS_Q_W      = SUM_W;

	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP_255 = 25'h1010102;

	localparam logic [VOL_W-1:0]   VOL_UNITY = 8'hFF;
	localparam logic [VOL_W-1:0]   VOL_MUTE  = 8'h00;
	localparam logic [COUNT_W-1:0] COUNT_RST = 3'd4;

	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MASTER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN0  = CFG_IDX_W'(2);

endpackage

[rtl/pcm_mixer_volume_saturate.sv]
// Top level of the PCM mixer: per-source volume, sum, master volume, clamp.
//
// Takes one frame of four signed 16-bit samples per clock while in_stall is low and returns
// one mixed sample per frame. Each volume stage divides by 255 through a reciprocal multiply
// followed by a one-step correction, which sets the depth: multiply, reciprocal multiply and
// correct for the sources, then a register for the sum, then the same three steps for the
// master volume, with the clamp in the last stage. Stages advance independently, so bubbles
// close up while the output is stalled; in_stall rises only when the output holds a result
// that is not taken and every stage behind it is full. The user must make configuration writes
// only after the block has drained, to take effect on frames accepted after; it is not enforced.
module pcm_mixer_volume_saturate
	import pcmmix_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [VOL_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample_0,
	input  logic signed [SAMPLE_W-1:0]  sample_1,
	input  logic signed [SAMPLE_W-1:0]  sample_2,
	input  logic signed [SAMPLE_W-1:0]  sample_3,
	input  logic                        last_frame,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  mixed_sample,
	output logic                        last
);

	logic [VOL_W-1:0]   master_q;
	logic [COUNT_W-1:0] count_q;
	logic [VOL_W-1:0]   gain_q [NUM_SOURCES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= VOL_UNITY;
			count_q  <= COUNT_RST;
			for (int c = 0; c < NUM_SOURCES; c++) begin
				gain_q[c] <= VOL_UNITY;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_MASTER) begin
				master_q <= cfg_data;
			end
			if (cfg_index == CFG_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int c = 0; c < NUM_SOURCES; c++) begin
				if (cfg_index == CFG_GAIN0 + CFG_IDX_W'(c)) begin
					gain_q[c] <= cfg_data;
				end
			end
		end
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7   = !valid_s7 || !out_stall;
	assign adv_s6   = !valid_s6 || adv_s7;
	assign adv_s5   = !valid_s5 || adv_s6;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign out_valid = valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
		end
	end

	// source lanes
	logic signed [SAMPLE_W-1:0]    smp_in [NUM_SOURCES];
	logic signed [CH_MAG_W+1:0]    ch_prod [NUM_SOURCES];
	logic [CH_MAG_W+RECIP_W-1:0]   ch_est [NUM_SOURCES];
	logic [CH_MAG_W:0]             ch_p255 [NUM_SOURCES];
	logic [CH_Q_W-1:0]             ch_qc [NUM_SOURCES];
	logic signed [SAMPLE_W-1:0]    ch_val [NUM_SOURCES];

	logic signed [SAMPLE_W-1:0]    smp_s1 [NUM_SOURCES];
	logic [CH_MAG_W-1:0]           mag_s1 [NUM_SOURCES];
	logic                          neg_s1 [NUM_SOURCES];
	logic                          zero_s1 [NUM_SOURCES];
	logic                          unity_s1 [NUM_SOURCES];
	logic                          last_s1;

	logic signed [SAMPLE_W-1:0]    smp_s2 [NUM_SOURCES];
	logic [CH_MAG_W-1:0]           mag_s2 [NUM_SOURCES];
	logic [CH_Q_W-1:0]             q_s2 [NUM_SOURCES];
	logic                          neg_s2 [NUM_SOURCES];
	logic                          zero_s2 [NUM_SOURCES];
	logic                          unity_s2 [NUM_SOURCES];
	logic                          last_s2;

	logic signed [SAMPLE_W-1:0]    scaled_s3 [NUM_SOURCES];
	logic                          last_s3;

	assign smp_in[0] = sample_0;
	assign smp_in[1] = sample_1;
	assign smp_in[2] = sample_2;
	assign smp_in[3] = sample_3;

	always_comb begin
		for (int c = 0; c < NUM_SOURCES; c++) begin
			ch_prod[c] = (CH_MAG_W+2)'(smp_in[c]) * $signed({1'b0, gain_q[c]});
			ch_est[c]  = {{RECIP_W{1'b0}}, mag_s1[c]} * {{CH_MAG_W{1'b0}}, RECIP_255};
			ch_p255[c] = {q_s2[c], 8'b0} - {8'b0, q_s2[c]};
			ch_qc[c]   = (ch_p255[c] > {1'b0, mag_s2[c]}) ? q_s2[c] - 1'b1 : q_s2[c];
			if (zero_s2[c]) begin
				ch_val[c] = '0;
			end else if (unity_s2[c]) begin
				ch_val[c] = smp_s2[c];
			end else if (neg_s2[c]) begin
				ch_val[c] = -$signed(ch_qc[c]);
			end else begin
				ch_val[c] = $signed(ch_qc[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			last_s1 <= last_frame;
			for (int c = 0; c < NUM_SOURCES; c++) begin
				smp_s1[c]   <= smp_in[c];
				neg_s1[c]   <= ch_prod[c][CH_MAG_W+1];
				mag_s1[c]   <= ch_prod[c][CH_MAG_W+1] ? CH_MAG_W'(-ch_prod[c])
					: CH_MAG_W'(ch_prod[c]);
				zero_s1[c]  <= (gain_q[c] == VOL_MUTE) || (COUNT_W'(c) >= count_q);
				unity_s1[c] <= gain_q[c] == VOL_UNITY;
			end
		end
		if (adv_s2) begin
			last_s2 <= last_s1;
			for (int c = 0; c < NUM_SOURCES; c++) begin
				smp_s2[c]   <= smp_s1[c];
				mag_s2[c]   <= mag_s1[c];
				q_s2[c]     <= ch_est[c][RECIP_SHIFT+CH_Q_W-1:RECIP_SHIFT];
				neg_s2[c]   <= neg_s1[c];
				zero_s2[c]  <= zero_s1[c];
				unity_s2[c] <= unity_s1[c];
			end
		end
		if (adv_s3) begin
			last_s3 <= last_s2;
			for (int c = 0; c < NUM_SOURCES; c++) begin
				scaled_s3[c] <= ch_val[c];
			end
		end
	end

	// sum and master volume
	logic signed [SUM_W-1:0]       sum_acc;
	logic signed [MS_MAG_W+1:0]    ms_prod;
	logic [MS_MAG_W+RECIP_W-1:0]   ms_est;
	logic [MS_Q_W+7:0]             ms_p255;
	logic [MS_Q_W-1:0]             ms_qc;
	logic signed [MS_Q_W:0]        ms_val;

	logic signed [SUM_W-1:0]       sum_s4;
	logic                          last_s4;
	logic signed [SUM_W-1:0]       sum_s5;
	logic [MS_MAG_W-1:0]           mag_s5;
	logic                          neg_s5, zero_s5, unity_s5, last_s5;
	logic signed [SUM_W-1:0]       sum_s6;
	logic [MS_MAG_W-1:0]           mag_s6;
	logic [MS_Q_W-1:0]             q_s6;
	logic                          neg_s6, zero_s6, unity_s6, last_s6;

	always_comb begin
		sum_acc = '0;
		for (int c = 0; c < NUM_SOURCES; c++) begin
			sum_acc = sum_acc + SUM_W'(scaled_s3[c]);
		end
		ms_prod = (MS_MAG_W+2)'(sum_s4) * $signed({1'b0, master_q});
		ms_est  = {{RECIP_W{1'b0}}, mag_s5} * {{MS_MAG_W{1'b0}}, RECIP_255};
		ms_p255 = {q_s6, 8'b0} - {8'b0, q_s6};
		ms_qc   = (ms_p255 > (MS_Q_W+8)'(mag_s6)) ? q_s6 - 1'b1 : q_s6;
		if (zero_s6) begin
			ms_val = '0;
		end else if (unity_s6) begin
			ms_val = (MS_Q_W+1)'(sum_s6);
		end else if (neg_s6) begin
			ms_val = -$signed({1'b0, ms_qc});
		end else begin
			ms_val = $signed({1'b0, ms_qc});
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			sum_s4  <= sum_acc;
			last_s4 <= last_s3;
		end
		if (adv_s5) begin
			sum_s5   <= sum_s4;
			neg_s5   <= ms_prod[MS_MAG_W+1];
			mag_s5   <= ms_prod[MS_MAG_W+1] ? MS_MAG_W'(-ms_prod) : MS_MAG_W'(ms_prod);
			zero_s5  <= master_q == VOL_MUTE;
			unity_s5 <= master_q == VOL_UNITY;
			last_s5  <= last_s4;
		end
		if (adv_s6) begin
			sum_s6   <= sum_s5;
			mag_s6   <= mag_s5;
			q_s6     <= ms_est[RECIP_SHIFT+MS_Q_W-1:RECIP_SHIFT];
			neg_s6   <= neg_s5;
			zero_s6  <= zero_s5;
			unity_s6 <= unity_s5;
			last_s6  <= last_s5;
		end
		if (adv_s7) begin
			if (ms_val < (MS_Q_W+1)'(OUT_MIN)) begin
				mixed_sample <= OUT_MIN;
			end else if (ms_val > (MS_Q_W+1)'(OUT_MAX)) begin
				mixed_sample <= OUT_MAX;
			end else begin
				mixed_sample <= SAMPLE_W'(ms_val);
			end
			last <= last_s6;
		end
	end

endmodule

[rtl/pcmmix_checker.sv]
// Port-level checks of the PCM mixer, bound to the top level.
module pcmmix_checker
	import pcmmix_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] mixed_sample,
	input logic                       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mixed_sample) && $stable(last))
		else $error("stalled output payload changed");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while output is free");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind pcm_mixer_volume_saturate pcmmix_checker u_pcmmix_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mixed_sample (mixed_sample),
	.last         (last)
);

[dv/tb_pcm_mixer_volume_saturate.sv]
// Testbench for the PCM mixer: predicted mix per frame, register settings, random stalls.
module tb_pcm_mixer_volume_saturate;
	timeunit 1ns;
	timeprecision 1ps;

	import pcmmix_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int FRAMES_PER_PHASE = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_GAIN0 + NUM_SOURCES);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_SPARE_A + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix;
		logic                       last;
	} mix_result_t;

	class mix_scoreboard;
		logic [VOL_W-1:0]   master_vol;
		logic [COUNT_W-1:0] chan_count;
		logic [VOL_W-1:0]   gain [NUM_SOURCES];
		mix_result_t        expected_mix [$];
		int                 errors;

		function new();
			master_vol = VOL_UNITY;
			chan_count = COUNT_RST;
			foreach (gain[i]) gain[i] = VOL_UNITY;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VOL_W-1:0] data);
			if (idx == CFG_MASTER) begin
				master_vol = data;
			end else if (idx == CFG_COUNT) begin
				chan_count = data[COUNT_W-1:0];
			end else if (idx >= CFG_GAIN0 && idx < CFG_GAIN0 + NUM_SOURCES) begin
				gain[int'(idx) - int'(CFG_GAIN0)] = data;
			end
		endfunction

		function int scale_by_volume(int x, logic [VOL_W-1:0] vol);
			int v;
			int unity;
			v = vol;
			unity = VOL_UNITY;
			if (vol == VOL_MUTE) return 0;
			if (vol == VOL_UNITY) return x;
			return (x * v) / unity;
		endfunction

		function void note_frame(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
				logic signed [SAMPLE_W-1:0] s2, logic signed [SAMPLE_W-1:0] s3, logic lf);
			logic signed [SAMPLE_W-1:0] smp [NUM_SOURCES];
			int n;
			int acc;
			mix_result_t r;
			smp[0] = s0;
			smp[1] = s1;
			smp[2] = s2;
			smp[3] = s3;
			n = (chan_count > NUM_SOURCES) ? NUM_SOURCES : int'(chan_count);
			acc = 0;
			for (int c = 0; c < n; c++) acc += scale_by_volume(int'(smp[c]), gain[c]);
			acc = scale_by_volume(acc, master_vol);
			if (acc < int'(OUT_MIN)) acc = int'(OUT_MIN);
			if (acc > int'(OUT_MAX)) acc = int'(OUT_MAX);
			r.mix = acc[SAMPLE_W-1:0];
			r.last = lf;
			expected_mix.push_back(r);
		endfunction

		function void check_mix(logic signed [SAMPLE_W-1:0] got, logic got_last);
			mix_result_t want;
			if (expected_mix.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual mixed_sample=%0d last=%0d",
					$time, got, got_last);
				return;
			end
			want = expected_mix.pop_front();
			if (want.mix !== got) begin
				errors++;
				$display("%0t: mixed_sample expected %0d actual %0d", $time, want.mix, got);
			end
			if (want.last !== got_last) begin
				errors++;
				$display("%0t: last expected %0d actual %0d", $time, want.last, got_last);
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [VOL_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_0;
	logic signed [SAMPLE_W-1:0] sample_1;
	logic signed [SAMPLE_W-1:0] sample_2;
	logic signed [SAMPLE_W-1:0] sample_3;
	logic                       last_frame;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       last;

	int            send_idle_pct;
	int            recv_idle_pct;
	int            cycle_count;
	mix_scoreboard sb;

	pcm_mixer_volume_saturate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_0     (sample_0),
		.sample_1     (sample_1),
		.sample_2     (sample_2),
		.sample_3     (sample_3),
		.last_frame   (last_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mixed_sample (mixed_sample),
		.last         (last)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_mix(mixed_sample, last);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(5))
			0: return SAMPLE_W'(OUT_MAX - $urandom_range(3));
			1: return SAMPLE_W'(OUT_MIN + $urandom_range(3));
			2: return SAMPLE_W'($urandom_range(600) - 300);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [VOL_W-1:0] pick_volume();
		case ($urandom_range(3))
			0: return VOL_MUTE;
			1: return VOL_UNITY;
			default: return VOL_W'($urandom);
		endcase
	endfunction

	function automatic logic [VOL_W-1:0] count_word(int n);
		return VOL_W'(($urandom & 32'hF8) | n);
	endfunction

	task automatic send_frame(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
			logic signed [SAMPLE_W-1:0] s2, logic signed [SAMPLE_W-1:0] s3, logic lf);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		sample_0   <= s0;
		sample_1   <= s1;
		sample_2   <= s2;
		sample_3   <= s3;
		last_frame <= lf;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_frame(s0, s1, s2, s3, lf);
		@(negedge clk);
	endtask

	task automatic send_random_frame();
		send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
			$urandom_range(7) == 0);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [VOL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic program_mixer(logic [VOL_W-1:0] mv, logic [VOL_W-1:0] cnt,
			logic [VOL_W-1:0] g0, logic [VOL_W-1:0] g1, logic [VOL_W-1:0] g2,
			logic [VOL_W-1:0] g3);
		set_reg(CFG_MASTER, mv);
		set_reg(CFG_COUNT, cnt);
		set_reg(CFG_GAIN0, g0);
		set_reg(CFG_IDX_W'(CFG_GAIN0 + 1), g1);
		set_reg(CFG_IDX_W'(CFG_GAIN0 + 2), g2);
		set_reg(CFG_IDX_W'(CFG_GAIN0 + 3), g3);
		set_reg(CFG_SPARE_A, VOL_W'($urandom));
		set_reg(CFG_SPARE_B, VOL_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [VOL_W-1:0] mv;
		logic [VOL_W-1:0] cnt;
		logic [VOL_W-1:0] g [NUM_SOURCES];
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_MASTER;
		cfg_data   = '0;
		in_valid   = 1'b0;
		sample_0   = '0;
		sample_1   = '0;
		sample_2   = '0;
		sample_3   = '0;
		last_frame = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 58;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX, 1'b1);
		send_frame(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN, 1'b0);
		send_frame(OUT_MAX, OUT_MIN, OUT_MAX, OUT_MIN, 1'b1);
		send_frame(16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0);
		send_frame(16'sh4000, 16'sh4000, -16'sd1, 16'sd0, 1'b0);
		send_frame(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1);
		send_frame(16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 1'b0);
		drain();

		program_mixer(8'd254, 8'hFC, 8'd1, 8'd254, 8'd128, VOL_MUTE);
		send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX, 1'b0);
		send_frame(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN, 1'b1);
		send_frame(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0);
		send_frame(16'sd255, -16'sd255, 16'sd255, -16'sd255, 1'b0);
		send_frame(16'sd254, 16'sd256, -16'sd3, 16'sd7, 1'b1);
		send_frame(-16'sd254, 16'sd1000, 16'sd511, OUT_MAX, 1'b0);
		drain();

		program_mixer(8'd128, 8'h00, VOL_UNITY, VOL_UNITY, VOL_UNITY, VOL_UNITY);
		send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX, 1'b1);
		send_frame(OUT_MIN, 16'sd5, 16'sd9, -16'sd9, 1'b0);
		drain();

		program_mixer(VOL_UNITY, 8'h07, VOL_UNITY, VOL_UNITY, VOL_UNITY, VOL_UNITY);
		send_frame(OUT_MAX, OUT_MAX, 16'sd2, OUT_MIN, 1'b0);
		send_frame(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MAX, 1'b1);
		send_frame(16'sd100, 16'sd200, 16'sd300, 16'sd400, 1'b0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 58;
			end else if (p < 6) begin
				send_idle_pct = 58;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			mv  = pick_volume();
			cnt = count_word($urandom_range(7));
			foreach (g[i]) g[i] = pick_volume();
			case (p)
				0: begin
					mv  = VOL_UNITY;
					cnt = count_word(NUM_SOURCES);
					foreach (g[i]) g[i] = VOL_UNITY;
				end
				1: mv = VOL_MUTE;
				2: cnt = count_word(0);
				3: cnt = count_word(7);
				4: cnt = count_word(1);
				5: cnt = count_word(2);
				6: cnt = count_word(3);
				default: mv = VOL_W'($urandom);
			endcase
			program_mixer(mv, cnt, g[0], g[1], g[2], g[3]);
			repeat (FRAMES_PER_PHASE) send_random_frame();
			drain();
		end

		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/pcmmix_pkg.sv
rtl/pcm_mixer_volume_saturate.sv
rtl/pcmmix_checker.sv
dv/tb_pcm_mixer_volume_saturate.sv
